@@ sv/ddtw_pkg.sv @@
// ----------------------------------------------------------------------------
// ddtw_pkg
// shared widths, tile codes and the divider result bundle for the
// decimal digit tile writer
// ----------------------------------------------------------------------------
package ddtw_pkg;

  localparam int unsigned VALUE_W = 16;
  localparam int unsigned DIGIT_W = 4;
  localparam int unsigned COORD_W = 8;
  localparam int unsigned CODE_W  = 5;

  localparam logic [CODE_W-1:0]  GLYPH_ZERO = 5'd16;
  localparam logic [CODE_W-1:0]  BLANK_TILE = 5'd0;
  localparam logic [DIGIT_W:0]   DIV_BASE   = 5'd10;

  // result of one divide-by-ten pass
  typedef struct packed {
    logic               done;
    logic [VALUE_W-1:0] quotient;
    logic [DIGIT_W-1:0] remainder;
  } div_res_t;

endpackage

@@ sv/ddtw_div10.sv @@
// ----------------------------------------------------------------------------
// ddtw_div10
// bit-serial divide by ten: one dividend bit per cycle, msb first,
// done pulses when quotient and remainder are ready
// ----------------------------------------------------------------------------
module ddtw_div10 (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [ddtw_pkg::VALUE_W-1:0] dividend,
  output ddtw_pkg::div_res_t           res
);
  import ddtw_pkg::*;

  localparam int unsigned CNT_W = $clog2(VALUE_W);

  logic [VALUE_W-1:0] shreg;
  logic [DIGIT_W-1:0] rem;
  logic [CNT_W-1:0]   cnt;
  logic               busy;
  logic               done;

  logic [DIGIT_W:0]   trial;
  logic               ge;
  logic [DIGIT_W:0]   trial_sub;

  assign trial     = {rem, shreg[VALUE_W-1]};
  assign ge        = (trial >= DIV_BASE);
  assign trial_sub = trial - DIV_BASE;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(VALUE_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // quotient bits shift in at the bottom as dividend bits leave the top
  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= dividend;
      rem   <= '0;
    end else if (busy) begin
      shreg <= {shreg[VALUE_W-2:0], ge};
      rem   <= ge ? trial_sub[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
    end
  end

  assign res.done      = done;
  assign res.quotient  = shreg;
  assign res.remainder = rem;

endmodule

@@ sv/decimal_digit_tile_writer.sv @@
// ----------------------------------------------------------------------------
// decimal_digit_tile_writer
// writes a number as a column of decimal digit tiles with leading zero
// blanking and optional two-zero padding
// ----------------------------------------------------------------------------
// One request at a time. A request yields 1 to 7 tile writes at rows counting
// down from start_row (wrapping at 0). A pad tile is registered in S_PAD and
// offered from S_OUT; each digit first goes through a bit-serial divide by
// ten (a start, a shift for every dividend bit, then the load of the tile)
// before its tile is offered, and then the tile waits for out_ready. in_ready
// is high only once the last tile of the previous request has been taken.
module decimal_digit_tile_writer (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [ddtw_pkg::COORD_W-1:0] column,
  input  logic [ddtw_pkg::COORD_W-1:0] start_row,
  input  logic [ddtw_pkg::VALUE_W-1:0] value,
  input  logic [ddtw_pkg::VALUE_W-1:0] bound_value,
  input  logic                         pad_two_zeros,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [ddtw_pkg::COORD_W-1:0] tile_column,
  output logic [ddtw_pkg::COORD_W-1:0] tile_row,
  output logic [ddtw_pkg::CODE_W-1:0]  tile_code,
  output logic                         last
);
  import ddtw_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_PAD  = 4'b0010,
    S_DIV  = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t             state;
  logic [COORD_W-1:0] col;
  logic [COORD_W-1:0] row;
  logic [VALUE_W-1:0] val;
  logic [VALUE_W-1:0] bnd;
  logic               first;
  logic               pad_left;
  logic               div_start;

  div_res_t           val_res;
  div_res_t           bnd_res;

  logic               in_acc;
  logic               out_acc;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign in_acc    = in_valid && in_ready;
  assign out_acc   = out_valid && out_ready;

  ddtw_div10 u_div_val (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (val),
    .res      (val_res)
  );

  ddtw_div10 u_div_bnd (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (bnd),
    .res      (bnd_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      div_start <= 1'b0;
      pad_left  <= 1'b0;
      first     <= 1'b0;
    end else begin
      div_start <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            first <= 1'b1;
            if (pad_two_zeros) begin
              pad_left <= 1'b1;
              state    <= S_PAD;
            end else begin
              div_start <= 1'b1;
              state     <= S_DIV;
            end
          end
        end
        S_PAD: begin
          state <= S_OUT;
        end
        S_DIV: begin
          if (val_res.done) begin
            first <= 1'b0;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_acc) begin
            priority if (last) begin
              state <= S_IDLE;
            end else if (pad_left) begin
              pad_left <= 1'b0;
              state    <= S_PAD;
            end else begin
              div_start <= 1'b1;
              state     <= S_DIV;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // payload: row holds the row of the next tile to be produced
  always_ff @(posedge clk) begin
    if (in_acc) begin
      col <= column;
      row <= start_row;
      val <= value;
      bnd <= bound_value;
    end
    if (state == S_PAD) begin
      tile_column <= col;
      tile_row    <= row;
      tile_code   <= GLYPH_ZERO;
      last        <= 1'b0;
      row         <= row - 1'b1;
    end
    if ((state == S_DIV) && val_res.done) begin
      tile_column <= col;
      tile_row    <= row;
      // blank once nothing is left above this place, but never the units digit
      tile_code   <= (!first && (val == '0)) ? BLANK_TILE
                   : GLYPH_ZERO + {1'b0, val_res.remainder};
      last        <= (bnd_res.quotient == '0);
      row         <= row - 1'b1;
      val         <= val_res.quotient;
      bnd         <= bnd_res.quotient;
    end
  end

`ifndef ASSERT_OFF
  a_code_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (tile_code == BLANK_TILE) ||
                  ((tile_code >= GLYPH_ZERO) && (tile_code <= GLYPH_ZERO + 5'd9)))
    else $error("tile code outside blank and digit glyphs");

  a_div_lockstep: assert property (@(posedge clk) disable iff (rst)
    val_res.done == bnd_res.done)
    else $error("value and bound dividers out of step");

  a_last_to_idle: assert property (@(posedge clk) disable iff (rst)
    (out_acc && last) |=> in_ready)
    else $error("block not idle after last tile taken");

  a_no_accept_mid: assert property (@(posedge clk) disable iff (rst)
    (out_acc && !last) |=> !in_ready)
    else $error("request accepted before its last tile");
`endif

endmodule

@@ tb/sv/tb_decimal_digit_tile_writer.sv @@
// ----------------------------------------------------------------------------
// tb_decimal_digit_tile_writer
// self-checking bench: directed and random requests go through a queue-fed
// driver, every tile write is checked against a local digit predictor
// ----------------------------------------------------------------------------
module tb_decimal_digit_tile_writer;

  timeunit 1ns;
  timeprecision 1ps;

  import ddtw_pkg::*;

  localparam int unsigned RADIX     = 10;
  localparam int unsigned DRAIN_CYC = 250;
  localparam int unsigned HOLD_CYC  = 400;

  typedef struct packed {
    logic [COORD_W-1:0] column;
    logic [COORD_W-1:0] start_row;
    logic [VALUE_W-1:0] value;
    logic [VALUE_W-1:0] bound_value;
    logic               pad;
  } digit_req_t;

  typedef struct packed {
    logic [COORD_W-1:0] column;
    logic [COORD_W-1:0] row;
    logic [CODE_W-1:0]  code;
    logic               last;
  } tile_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic               in_valid  = 1'b0;
  logic               in_ready;
  digit_req_t         req_r     = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [COORD_W-1:0] tile_column;
  logic [COORD_W-1:0] tile_row;
  logic [CODE_W-1:0]  tile_code;
  logic               last;

  digit_req_t pending_reqs[$];
  tile_t      expected_tiles[$];

  int unsigned send_idle_pct = 21;
  int unsigned recv_idle_pct = 76;
  int unsigned tiles_taken   = 0;
  int unsigned hold_left     = 0;
  bit          held_once     = 1'b0;
  int unsigned errors        = 0;

  decimal_digit_tile_writer i_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .column        (req_r.column),
    .start_row     (req_r.start_row),
    .value         (req_r.value),
    .bound_value   (req_r.bound_value),
    .pad_two_zeros (req_r.pad),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .tile_column   (tile_column),
    .tile_row      (tile_row),
    .tile_code     (tile_code),
    .last          (last)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // expected tile writes for one request, pad tiles first, units digit next
  function automatic void predict_tiles(digit_req_t r);
    tile_t           t;
    logic [COORD_W-1:0] row;
    int unsigned     val;
    int unsigned     bnd;
    bit              first;
    row   = r.start_row;
    val   = r.value;
    bnd   = r.bound_value;
    first = 1'b1;
    t.column = r.column;
    t.last   = 1'b0;
    if (r.pad) begin
      repeat (2) begin
        t.row  = row;
        t.code = GLYPH_ZERO;
        expected_tiles.push_back(t);
        row = row - 1'b1;
      end
    end
    do begin
      t.row  = row;
      // leading zero blanking, never on the units place
      if (!first && val == 0)
        t.code = BLANK_TILE;
      else
        t.code = GLYPH_ZERO + CODE_W'(val % RADIX);
      bnd = bnd / RADIX;
      t.last = (bnd == 0);
      expected_tiles.push_back(t);
      row   = row - 1'b1;
      val   = val / RADIX;
      first = 1'b0;
    end while (bnd > 0);
  endfunction

  function automatic digit_req_t random_req();
    digit_req_t r;
    int unsigned b;
    case ($urandom_range(0, 5))
      0: b = $urandom_range(0, 9);
      1: b = $urandom_range(10, 99);
      2: b = $urandom_range(100, 999);
      3: b = $urandom_range(1000, 9999);
      4: b = $urandom_range(10000, 65535);
      default: b = $urandom_range(0, 65535);
    endcase
    r.bound_value = VALUE_W'(b);
    case ($urandom_range(0, 5))
      0, 1: r.value = VALUE_W'($urandom_range(0, b));
      2: r.value = VALUE_W'($urandom_range(0, 65535));
      3: r.value = VALUE_W'($urandom_range(0, 99));
      4: r.value = '0;
      // sparse digits, zeros between nonzero places
      default: r.value = VALUE_W'($urandom_range(1, 6) * (10 ** $urandom_range(0, 4))
                                  + $urandom_range(0, 1) * 10000);
    endcase
    r.column    = COORD_W'($urandom_range(0, 255));
    r.start_row = ($urandom_range(0, 3) == 0) ? COORD_W'($urandom_range(0, 6))
                                              : COORD_W'($urandom_range(0, 255));
    r.pad       = 1'($urandom_range(0, 1));
    return r;
  endfunction

  task automatic add_req(input int unsigned col, input int unsigned row,
                         input int unsigned val, input int unsigned bnd,
                         input bit pad);
    digit_req_t r;
    r.column      = COORD_W'(col);
    r.start_row   = COORD_W'(row);
    r.value       = VALUE_W'(val);
    r.bound_value = VALUE_W'(bnd);
    r.pad         = pad;
    pending_reqs.push_back(r);
  endtask

  task automatic add_random(input int unsigned n);
    repeat (n) pending_reqs.push_back(random_req());
  endtask

  task automatic wait_sent();
    while (pending_reqs.size() != 0 || in_valid) @(posedge clk);
  endtask

  // driver
  always @(posedge clk) begin
    bit take;
    take = in_valid && in_ready;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (take)
        predict_tiles(req_r);
      if ((!in_valid || take) && pending_reqs.size() != 0
          && $urandom_range(0, 99) >= send_idle_pct) begin
        req_r    <= pending_reqs.pop_front();
        in_valid <= 1'b1;
      end else if (take) begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor and receiver
  always @(posedge clk) begin
    tile_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        tiles_taken++;
        if (expected_tiles.size() == 0) begin
          $error("tile write with no request pending: col %0d row %0d code %0d last %0d",
                 tile_column, tile_row, tile_code, last);
          errors++;
        end else begin
          want = expected_tiles.pop_front();
          if (tile_column !== want.column) begin
            $error("tile_column: expected %0d, got %0d", want.column, tile_column);
            errors++;
          end
          if (tile_row !== want.row) begin
            $error("tile_row: expected %0d, got %0d", want.row, tile_row);
            errors++;
          end
          if (tile_code !== want.code) begin
            $error("tile_code: expected %0d, got %0d", want.code, tile_code);
            errors++;
          end
          if (last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, last);
            errors++;
          end
        end
      end
      // one long hold-off so the block backs up and stalls its input
      if (!held_once && tiles_taken >= 60) begin
        held_once <= 1'b1;
        hold_left <= HOLD_CYC;
        out_ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: bound zero, dropped digits, row wrap, blanking, u8 case
    add_req(0,   0,   0,     0,     0);
    add_req(17,  3,   65535, 0,     0);
    add_req(255, 0,   65535, 65535, 1);
    add_req(128, 1,   0,     65535, 1);
    add_req(1,   255, 9,     9,     0);
    add_req(2,   128, 5,     10,    0);
    add_req(3,   4,   10001, 10000, 0);
    add_req(4,   2,   100,   9999,  1);
    add_req(5,   200, 255,   255,   0);
    add_req(6,   6,   7,     255,   0);
    add_req(254, 0,   12345, 1,     1);
    add_req(170, 85,  40000, 12345, 0);
    add_req(85,  170, 43690, 21845, 1);
    add_req(7,   1,   0,     0,     1);
    add_req(8,   5,   90,    99,    0);
    add_req(9,   100, 1000,  65535, 0);
    add_req(10,  50,  65535, 65535, 0);
    add_req(11,  0,   32768, 32768, 0);
    add_random(110);
    wait_sent();

    send_idle_pct = 76;
    recv_idle_pct = 21;
    add_random(125);
    wait_sent();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    add_random(125);
    wait_sent();

    while (expected_tiles.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    if (errors == 0 && expected_tiles.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  initial begin
    #1_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
